// File: design/fps_pkg.sv
// Shared types and constants for the fixed pattern stream substitute block.
package fps_pkg;

  localparam int BYTE_BITS    = 8;
  localparam int CFG_BITS     = 64;
  localparam int CFG_INDEX_W  = 3;
  localparam int WORD_BYTES   = 8;
  localparam int PAT_WORDS    = 4;
  localparam int POS_OUT_BITS = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SEARCH_0  = 3'd0,
    REG_SEARCH_1  = 3'd1,
    REG_SEARCH_2  = 3'd2,
    REG_SEARCH_3  = 3'd3,
    REG_REPLACE_0 = 3'd4,
    REG_REPLACE_1 = 3'd5,
    REG_REPLACE_2 = 3'd6,
    REG_REPLACE_3 = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic shift;
    logic replace;
  } chain_ctl_t;

endpackage

// File: design/fps_cell.sv
// One window cell: holds a byte, compares its incoming byte and loads it or the replacement.
module fps_cell
  import fps_pkg::*;
(
  input  logic                 clk,
  input  chain_ctl_t           ctl,
  input  logic [BYTE_BITS-1:0] in_byte,
  input  logic [BYTE_BITS-1:0] search_byte,
  input  logic [BYTE_BITS-1:0] replace_byte,
  output logic [BYTE_BITS-1:0] cell_byte,
  output logic                 match
);

  assign match = (in_byte == search_byte);

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      cell_byte <= ctl.replace ? replace_byte : in_byte;
    end
  end

endmodule

// File: design/fps_ctrl.sv
// Window fill, flush sequencing, stream position and the output register.
module fps_ctrl
  import fps_pkg::*;
#(
  parameter int PATTERN_BYTES = 32,
  parameter int POSITION_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    end_of_text,
  input  logic                    hit,
  input  logic [BYTE_BITS-1:0]    front_byte,
  input  logic [BYTE_BITS-1:0]    cell_bytes [PATTERN_BYTES],
  output chain_ctl_t              ctl,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [BYTE_BITS-1:0]    out_byte,
  output logic [POS_OUT_BITS-1:0] byte_position,
  output logic                    replace_start,
  output logic                    final_byte
);

  localparam int FILL_BITS = $clog2(PATTERN_BYTES + 1);
  localparam int IDX_BITS  = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;
  localparam logic [FILL_BITS-1:0] FILL_TOP  = FILL_BITS'(PATTERN_BYTES - 1);
  localparam logic [FILL_BITS-1:0] WIN_SIZE  = FILL_BITS'(PATTERN_BYTES);
  localparam logic [FILL_BITS-1:0] ONE       = FILL_BITS'(1);
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  logic [FILL_BITS-1:0]     fill, fill_next;
  logic [FILL_BITS-1:0]     remain, remain_next;
  logic                     flushing, flushing_next;
  logic [POSITION_BITS-1:0] pos, pos_next, pos_inc;
  logic                     out_valid_next;
  logic                     load;
  logic [BYTE_BITS-1:0]     load_byte;
  logic                     load_start, load_final;
  logic                     take, slot_free, full;
  logic [FILL_BITS-1:0]     head_diff;
  logic [IDX_BITS-1:0]      head_idx;

  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = flushing || !slot_free;
  assign take      = in_valid && !in_stall;
  assign full      = (fill == FILL_TOP);
  assign pos_inc   = (pos == POS_MAX) ? pos : pos + POSITION_BITS'(1);
  assign head_diff = WIN_SIZE - remain;
  assign head_idx  = head_diff[IDX_BITS-1:0];

  always_comb begin
    fill_next      = fill;
    remain_next    = remain;
    flushing_next  = flushing;
    pos_next       = pos;
    load           = 1'b0;
    load_byte      = front_byte;
    load_start     = 1'b0;
    load_final     = 1'b0;
    ctl.shift      = take;
    ctl.replace    = take && full && hit;
    if (take) begin
      if (full) begin
        load       = 1'b1;
        load_byte  = front_byte;
        load_start = hit;
        if (end_of_text) begin
          fill_next = '0;
          if (FILL_TOP == '0) begin
            load_final = 1'b1;
            pos_next   = '0;
          end else begin
            flushing_next = 1'b1;
            remain_next   = FILL_TOP;
            pos_next      = pos_inc;
          end
        end else begin
          pos_next = pos_inc;
        end
      end else if (end_of_text) begin
        fill_next     = '0;
        flushing_next = 1'b1;
        remain_next   = fill + ONE;
      end else begin
        fill_next = fill + ONE;
      end
    end else if (flushing && slot_free) begin
      load        = 1'b1;
      load_byte   = cell_bytes[head_idx];
      load_final  = (remain == ONE);
      remain_next = remain - ONE;
      if (remain == ONE) begin
        flushing_next = 1'b0;
        pos_next      = '0;
      end else begin
        pos_next = pos_inc;
      end
    end
    if (load) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      remain    <= '0;
      flushing  <= 1'b0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      fill      <= fill_next;
      remain    <= remain_next;
      flushing  <= flushing_next;
      pos       <= pos_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte      <= load_byte;
      byte_position <= POS_OUT_BITS'(pos);
      replace_start <= load_start;
      final_byte    <= load_final;
    end
  end

endmodule

// File: design/fixed_pattern_stream_substitute.sv
// Top level: configuration registers, the row of window cells and the controller.
// An item that fills the window leaves the front byte of the window in the output register
// in the cycle after it is accepted. Throughput: one item per cycle while the output drains.
// An item that ends the text starts a flush of the window, one byte per cycle while the output
// drains, during which no item is accepted; the flush emits up to PATTERN_BYTES - 1 bytes.
// Reset clears the pattern registers, the fill count, the position and the output valid.
module fixed_pattern_stream_substitute
  import fps_pkg::*;
#(
  parameter int PATTERN_BYTES = 32,
  parameter int POSITION_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [BYTE_BITS-1:0]    data_byte,
  input  logic                    end_of_text,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [BYTE_BITS-1:0]    out_byte,
  output logic [POS_OUT_BITS-1:0] byte_position,
  output logic                    replace_start,
  output logic                    final_byte
);

  logic [PAT_WORDS-1:0][CFG_BITS-1:0] search_words;
  logic [PAT_WORDS-1:0][CFG_BITS-1:0] replace_words;

  logic [BYTE_BITS-1:0]     cell_q   [PATTERN_BYTES];
  logic [BYTE_BITS-1:0]     cell_in  [PATTERN_BYTES];
  logic [BYTE_BITS-1:0]     srch_b   [PATTERN_BYTES];
  logic [BYTE_BITS-1:0]     repl_b   [PATTERN_BYTES];
  logic [PATTERN_BYTES-1:0] match;
  logic                     hit;
  logic [BYTE_BITS-1:0]     front_byte;
  chain_ctl_t               ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_words  <= '0;
      replace_words <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_SEARCH_0:  search_words[0]  <= cfg_data;
        REG_SEARCH_1:  search_words[1]  <= cfg_data;
        REG_SEARCH_2:  search_words[2]  <= cfg_data;
        REG_SEARCH_3:  search_words[3]  <= cfg_data;
        REG_REPLACE_0: replace_words[0] <= cfg_data;
        REG_REPLACE_1: replace_words[1] <= cfg_data;
        REG_REPLACE_2: replace_words[2] <= cfg_data;
        REG_REPLACE_3: replace_words[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < PATTERN_BYTES; i++) begin : g_cell
    assign srch_b[i] = search_words[i / WORD_BYTES][(i % WORD_BYTES) * BYTE_BITS +: BYTE_BITS];
    assign repl_b[i] = replace_words[i / WORD_BYTES][(i % WORD_BYTES) * BYTE_BITS +: BYTE_BITS];
    if (i == PATTERN_BYTES - 1) begin : g_tail
      assign cell_in[i] = data_byte;
    end else begin : g_body
      assign cell_in[i] = cell_q[i + 1];
    end
    fps_cell u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .in_byte      (cell_in[i]),
      .search_byte  (srch_b[i]),
      .replace_byte (repl_b[i]),
      .cell_byte    (cell_q[i]),
      .match        (match[i])
    );
  end

  assign hit        = &match;
  assign front_byte = ctl.replace ? repl_b[0] : cell_in[0];

  fps_ctrl #(
    .PATTERN_BYTES (PATTERN_BYTES),
    .POSITION_BITS (POSITION_BITS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .end_of_text   (end_of_text),
    .hit           (hit),
    .front_byte    (front_byte),
    .cell_bytes    (cell_q),
    .ctl           (ctl),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .byte_position (byte_position),
    .replace_start (replace_start),
    .final_byte    (final_byte)
  );

endmodule

// File: design/fps_checker.sv
// Port-level checks for the fixed pattern stream substitute block, bound to the top level.
module fps_checker
  import fps_pkg::*;
#(
  parameter int PATTERN_BYTES = 32
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    end_of_text,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [BYTE_BITS-1:0]    out_byte,
  input logic [POS_OUT_BITS-1:0] byte_position,
  input logic                    replace_start,
  input logic                    final_byte
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("Output item dropped while stalled.");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_byte) && $stable(byte_position)
      && $stable(replace_start) && $stable(final_byte))
    else $error("Stalled output item changed.");

  a_no_take_when_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("Input accepted while the output register is held.");

  a_flush_blocks: assert property (@(posedge clk) disable iff (rst)
    (PATTERN_BYTES > 1) && in_valid && !in_stall && end_of_text |=> in_stall)
    else $error("Input accepted during a window flush.");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("Block not idle after reset.");

endmodule

bind fixed_pattern_stream_substitute fps_checker #(
  .PATTERN_BYTES (PATTERN_BYTES)
) u_fps_checker (.*);

// File: test/fps_checker.sv
// Checker that predicts the rewritten byte stream and compares it with the block's output.
module fps_substitute_checker
  import fps_pkg::*;
#(
  parameter int PATTERN_BYTES = 32,
  parameter int POSITION_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [BYTE_BITS-1:0]    data_byte,
  input  logic                    end_of_text,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [BYTE_BITS-1:0]    out_byte,
  input  logic [POS_OUT_BITS-1:0] byte_position,
  input  logic                    replace_start,
  input  logic                    final_byte,
  output int unsigned             mismatches,
  output int unsigned             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned POS_LIMIT = (64'd1 << POSITION_BITS) - 1;

  typedef struct packed {
    logic [BYTE_BITS-1:0]    value;
    logic [POS_OUT_BITS-1:0] position;
    logic                    start;
    logic                    tail;
  } stream_byte_t;

  stream_byte_t         rewritten_q[$];
  logic [CFG_BITS-1:0]  pattern_reg [2*PAT_WORDS];
  logic [BYTE_BITS-1:0] win_byte [PATTERN_BYTES];
  logic                 win_start [PATTERN_BYTES];
  int unsigned          win_fill;
  longint unsigned      next_pos;
  int unsigned          err_count = 0;

  function automatic logic [BYTE_BITS-1:0] pattern_byte(input int base, input int idx);
    return pattern_reg[base + idx / WORD_BYTES][(idx % WORD_BYTES) * BYTE_BITS +: BYTE_BITS];
  endfunction

  task automatic clear_window();
    foreach (win_byte[i]) begin
      win_byte[i] = '0;
      win_start[i] = 1'b0;
    end
    win_fill = 0;
    next_pos = 0;
  endtask

  task automatic emit_front(input logic tail);
    stream_byte_t item;
    int i;
    item.value = win_byte[0];
    item.position = next_pos[POS_OUT_BITS-1:0];
    item.start = win_start[0];
    item.tail = tail;
    rewritten_q = {rewritten_q, item};
    if (next_pos < POS_LIMIT) next_pos++;
    for (i = 0; i + 1 < win_fill; i++) begin
      win_byte[i] = win_byte[i+1];
      win_start[i] = win_start[i+1];
    end
    if (win_fill > 0) win_fill--;
    win_byte[win_fill] = '0;
    win_start[win_fill] = 1'b0;
  endtask

  task automatic substitute_step(input logic [BYTE_BITS-1:0] b, input logic eot);
    logic hit;
    int i;
    if (win_fill >= PATTERN_BYTES) win_fill = PATTERN_BYTES - 1;
    win_byte[win_fill] = b;
    win_start[win_fill] = 1'b0;
    win_fill++;
    if (win_fill == PATTERN_BYTES) begin
      hit = 1'b1;
      for (i = 0; i < PATTERN_BYTES; i++)
        if (win_byte[i] != pattern_byte(REG_SEARCH_0, i)) hit = 1'b0;
      if (hit) begin
        for (i = 0; i < PATTERN_BYTES; i++) win_byte[i] = pattern_byte(REG_REPLACE_0, i);
        win_start[0] = 1'b1;
      end
      emit_front(eot && win_fill == 1);
    end
    if (eot) begin
      while (win_fill > 0) emit_front(win_fill == 1);
      clear_window();
    end
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t ns: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    stream_byte_t want;
    if (rst) begin
      foreach (pattern_reg[r]) pattern_reg[r] = '0;
      clear_window();
      rewritten_q.delete();
    end else begin
      if (cfg_write) pattern_reg[cfg_index] = cfg_data;
      if (in_valid && !in_stall) substitute_step(data_byte, end_of_text);
      if (out_valid && !out_stall) begin
        if (rewritten_q.size() == 0) begin
          $display("%0t ns: item expected none actual byte 0x%0h position %0d",
                   $time, out_byte, byte_position);
          err_count++;
        end else begin
          want = rewritten_q.pop_front();
          check_field("out_byte", want.value, out_byte);
          check_field("byte_position", want.position, byte_position);
          check_field("replace_start", want.start, replace_start);
          check_field("final_byte", want.tail, final_byte);
        end
      end
    end
    mismatches <= err_count;
    pending <= rewritten_q.size();
  end

endmodule

// File: test/fixed_pattern_stream_substitute_tb.sv
// Testbench top: clock, reset, pattern loading, byte stream stimulus and the final verdict.
module fixed_pattern_stream_substitute_tb;
  import fps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAT_LEN        = 32;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;

  typedef enum int {
    SET_RANDOM,
    SET_ONES_TO_ZEROS,
    SET_OVERLAP,
    SET_IDENTITY,
    SET_ZEROS_TO_ONES,
    SET_TWO_SYMBOL
  } setting_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0]  cfg_index = REG_SEARCH_0;
  logic [CFG_BITS-1:0]     cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [BYTE_BITS-1:0]    data_byte = '0;
  logic                    end_of_text = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [BYTE_BITS-1:0]    out_byte;
  logic [POS_OUT_BITS-1:0] byte_position;
  logic                    replace_start;
  logic                    final_byte;
  int unsigned             mismatches;
  int unsigned             pending;

  logic [BYTE_BITS-1:0] search_pat [PAT_LEN];
  logic [BYTE_BITS-1:0] repl_pat [PAT_LEN];
  logic                 calm = 1'b0;
  logic                 hold_go = 1'b0;
  logic                 hold_done = 1'b0;
  int                   hold_left = 0;

  fixed_pattern_stream_substitute #(
    .PATTERN_BYTES(PAT_LEN),
    .POSITION_BITS(32)
  ) i_dut (.*);

  fps_substitute_checker #(
    .PATTERN_BYTES(PAT_LEN),
    .POSITION_BITS(32)
  ) i_checker (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 20);
    end
  end

  task automatic send_byte(input logic [BYTE_BITS-1:0] b, input logic last);
    while (!calm && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    end_of_text <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_text(input int segments);
    logic [BYTE_BITS-1:0] text[$];
    int k, j, kind, cut, spot;
    for (k = 0; k < segments; k++) begin
      kind = (k == 0 && segments >= 2) ? 0 : $urandom_range(9);
      case (kind)
        0, 1, 2, 3: for (j = 0; j < PAT_LEN; j++) text = {text, search_pat[j]};
        4, 5: begin
          cut = $urandom_range(1, PAT_LEN - 1);
          for (j = 0; j < cut; j++) text = {text, search_pat[j]};
        end
        6: begin
          spot = $urandom_range(PAT_LEN - 1);
          for (j = 0; j < PAT_LEN; j++)
            text = {text, (j == spot) ? search_pat[j] ^ 8'($urandom_range(1, 255))
                                      : search_pat[j]};
        end
        default: repeat ($urandom_range(1, 6)) text = {text, 8'($urandom)};
      endcase
    end
    foreach (text[i]) send_byte(text[i], i == text.size() - 1);
  endtask

  task automatic load_patterns();
    logic [CFG_BITS-1:0] word;
    int r, j, at;
    for (r = REG_SEARCH_0; r <= REG_REPLACE_3; r++) begin
      for (j = 0; j < WORD_BYTES; j++) begin
        at = (r % PAT_WORDS) * WORD_BYTES + j;
        word[j*BYTE_BITS +: BYTE_BITS] = (r < REG_REPLACE_0) ? search_pat[at] : repl_pat[at];
      end
      cfg_write <= 1'b1;
      cfg_index <= cfg_reg_t'(r);
      cfg_data <= word;
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  task automatic wait_drained(input int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("fixed_pattern_stream_substitute regression: fail");
    $finish;
  end

  initial begin : stimulus
    logic [BYTE_BITS-1:0] corner [8];
    logic [BYTE_BITS-1:0] sym;
    int s, t;
    corner = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Streams shorter than the window under the reset patterns.
    send_byte(8'hFF, 1'b1);
    foreach (corner[i]) send_byte(corner[i], i == $size(corner) - 1);
    for (t = 0; t < 12; t++) send_byte(8'($urandom), t == 11);

    for (s = SET_RANDOM; s <= SET_TWO_SYMBOL; s++) begin
      wait_drained(4);
      case (setting_t'(s))
        SET_RANDOM: foreach (search_pat[i]) begin
          search_pat[i] = 8'($urandom);
          repl_pat[i] = 8'($urandom);
        end
        SET_ONES_TO_ZEROS: foreach (search_pat[i]) begin
          search_pat[i] = 8'hFF;
          repl_pat[i] = 8'h00;
        end
        SET_OVERLAP: begin
          sym = 8'($urandom);
          foreach (search_pat[i]) begin
            search_pat[i] = sym;
            repl_pat[i] = sym;
          end
          repl_pat[0] = ~sym;
        end
        SET_IDENTITY: foreach (search_pat[i]) begin
          search_pat[i] = 8'($urandom);
          repl_pat[i] = search_pat[i];
        end
        SET_ZEROS_TO_ONES: foreach (search_pat[i]) begin
          search_pat[i] = 8'h00;
          repl_pat[i] = 8'hFF;
        end
        default: begin
          sym = 8'($urandom);
          foreach (search_pat[i]) begin
            search_pat[i] = $urandom_range(1) ? sym : ~sym;
            repl_pat[i] = 8'($urandom);
          end
        end
      endcase
      load_patterns();
      calm <= (s == SET_OVERLAP);
      if (s == SET_IDENTITY) begin
        hold_go <= 1'b1;
        send_text(2);
      end else begin
        send_text(1);
      end
    end

    wait_drained(DRAIN_CYCLES);
    if (mismatches == 0 && pending == 0)
      $display("fixed_pattern_stream_substitute regression: pass");
    else
      $display("fixed_pattern_stream_substitute regression: fail");
    $finish;
  end

endmodule

// File: fixed_pattern_stream_substitute.f
design/fps_pkg.sv
design/fps_cell.sv
design/fps_ctrl.sv
design/fixed_pattern_stream_substitute.sv
design/fps_checker.sv
test/fps_checker.sv
test/fixed_pattern_stream_substitute_tb.sv
